[hdl/nlsa_pkg.sv]
`timescale 1ns / 1ps

package nlsa_pkg;

    localparam int INDEX_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int NORM_STEPS   = 6;
    localparam int DIV_STEPS    = 60;
    localparam int HORNER_STEPS = 6;

    localparam logic [63:0] ONE60 = 64'h1000_0000_0000_0000;
    localparam logic [63:0] ONE61 = 64'h2000_0000_0000_0000;
    localparam logic [63:0] TWO61 = 64'h4000_0000_0000_0000;

    localparam logic [63:0] SQRT2_Q61   = 64'h2D41_3CCC_FE77_9921;
    localparam logic [63:0] LOG10_2_Q64 = 64'd5553023288523357132;
    localparam logic [63:0] LOG10_E_Q64 = 64'd8011319160293570762;

    // Series coefficients, round(2^60 / n).
    localparam logic [63:0] COEF_3  = (ONE60 + 64'd1) / 64'd3;
    localparam logic [63:0] COEF_5  = (ONE60 + 64'd2) / 64'd5;
    localparam logic [63:0] COEF_7  = (ONE60 + 64'd3) / 64'd7;
    localparam logic [63:0] COEF_9  = (ONE60 + 64'd4) / 64'd9;
    localparam logic [63:0] COEF_11 = (ONE60 + 64'd5) / 64'd11;
    localparam logic [63:0] COEF_13 = (ONE60 + 64'd6) / 64'd13;

    typedef struct packed {
        logic [31:0] idx;
        logic [63:0] x;
        logic [63:0] base;
        logic [47:0] smag;
        logic        sneg;
        logic        last;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } mul_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_FOLD,
        ST_DIV,
        ST_MUL,
        ST_POST,
        ST_SCORE,
        ST_UPDATE
    } state_t;

    typedef enum logic [2:0] {
        OP_SQ,
        OP_HORN,
        OP_LN,
        OP_LNT,
        OP_EXP,
        OP_TERM
    } op_t;

    // Coefficient added after Horner pass k, from 1/11 down to 1.
    function automatic logic [63:0] horner_coef(input logic [2:0] k);
        logic [63:0] c;
        case (k)
            3'd0:    c = COEF_11;
            3'd1:    c = COEF_9;
            3'd2:    c = COEF_7;
            3'd3:    c = COEF_5;
            3'd4:    c = COEF_3;
            default: c = ONE60;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] norm_amt(input logic [2:0] k);
        logic [6:0] a;
        case (k)
            3'd0:    a = 7'd32;
            3'd1:    a = 7'd16;
            3'd2:    a = 7'd8;
            3'd3:    a = 7'd4;
            3'd4:    a = 7'd2;
            default: a = 7'd1;
        endcase
        return a;
    endfunction

endpackage

[hdl/nlsa_front.sv]
`timescale 1ns / 1ps

module nlsa_front #(
    parameter int INDEX_BITS = nlsa_pkg::INDEX_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         cand_index,
    input  logic [62:0]         residual,
    input  logic signed [63:0]  base_term,
    input  logic signed [47:0]  scale_term,
    input  logic                run_last,
    output logic                q_valid,
    output nlsa_pkg::item_t     q_item,
    input  logic                q_pop
);

    localparam int PTR_BITS = $clog2(nlsa_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(nlsa_pkg::QUEUE_DEPTH + 1);

    nlsa_pkg::item_t             q_mem_reg [nlsa_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    nlsa_pkg::item_t             entry;
    logic                        push;
    logic [31:0]                 idx_mask;

    // Classify the incoming item: add the one-LSB offset, mask the index,
    // and split the scale into sign and magnitude.
    always_comb
    begin
        idx_mask    = 32'((33'd1 << INDEX_BITS) - 33'd1);
        entry.idx   = cand_index & idx_mask;
        entry.x     = {1'b0, residual} + 64'd1;
        entry.base  = base_term;
        entry.sneg  = scale_term[47];
        entry.smag  = scale_term[47] ? (48'd0 - scale_term) : scale_term;
        entry.last  = run_last;
    end

    assign in_stall = (cnt_reg == CNT_BITS'(nlsa_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(nlsa_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(nlsa_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

[hdl/nlsa_mul.sv]
`timescale 1ns / 1ps

module nlsa_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  nlsa_pkg::mul_req_t  req,
    output nlsa_pkg::mul_rsp_t  rsp
);

    // 64x64 product from four 32x32 partial products, one per cycle.
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   sh_reg, sh_next;
    logic [2:0]   ph_reg, ph_next;
    logic         run_reg, run_next;
    logic         done_reg, done_next;
    logic [31:0]  ai, bi;
    logic [6:0]   shamt;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        ph_next   = ph_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        ai        = ph_reg[0] ? a_reg[63:32] : a_reg[31:0];
        bi        = ph_reg[1] ? b_reg[63:32] : b_reg[31:0];
        shamt     = 7'(32 * (int'(sh_reg[0]) + int'(sh_reg[1])));
        if (req.start)
        begin
            a_next   = req.a;
            b_next   = req.b;
            acc_next = '0;
            ph_next  = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (ph_reg < 3'd4)
            begin
                pp_next = {32'd0, ai} * {32'd0, bi};
                sh_next = ph_reg[1:0];
            end
            if (ph_reg != 3'd0)
            begin
                acc_next = acc_reg + ({64'd0, pp_reg} << shamt);
            end
            if (ph_reg == 3'd4)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            ph_next = ph_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            ph_reg   <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

[hdl/nlsa_back.sv]
`timescale 1ns / 1ps

module nlsa_back #(
    parameter int INDEX_BITS = nlsa_pkg::INDEX_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  nlsa_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [63:0]  best_score,
    output logic [31:0]         best_at
);

    nlsa_pkg::state_t   state_reg, state_next;
    nlsa_pkg::op_t      op_reg, op_next;
    nlsa_pkg::item_t    item_reg, item_next;
    nlsa_pkg::mul_req_t mreq_reg, mreq_next;
    nlsa_pkg::mul_rsp_t mrsp;

    logic [63:0]        z_reg, z_next;
    logic [5:0]         lz_reg, lz_next;
    logic [5:0]         step_reg, step_next;
    logic signed [7:0]  e_reg, e_next;
    logic               fneg_reg, fneg_next;
    logic [63:0]        rem_reg, rem_next;
    logic [63:0]        den_reg, den_next;
    logic [63:0]        t_reg, t_next;
    logic [63:0]        s_reg, s_next;
    logic [63:0]        poly_reg, poly_next;
    logic [63:0]        lnterm_reg, lnterm_next;
    logic               lneg_reg, lneg_next;
    logic [63:0]        term_reg, term_next;
    logic [63:0]        score_reg, score_next;

    logic signed [63:0]     min_reg, min_next;
    logic [INDEX_BITS-1:0]  min_idx_reg, min_idx_next;
    logic                   have_reg, have_next;
    logic                   out_valid_reg, out_valid_next;
    logic [63:0]            out_score_reg, out_score_next;
    logic [INDEX_BITS-1:0]  out_idx_reg, out_idx_next;

    logic               out_free;
    logic [6:0]         amt;
    logic [63:0]        topmask;
    logic [63:0]        mn;
    logic [63:0]        rem2;
    logic [127:0]       rnd;
    logic [63:0]        prod_q60;
    logic [63:0]        eterm;
    logic [63:0]        lg;
    logic [7:0]         ae;
    logic [64:0]        sum;
    logic               take;

    nlsa_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq_reg),
        .rsp   (mrsp)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nlsa_pkg::ST_IDLE:
                if (q_valid)
                    state_next = nlsa_pkg::ST_NORM;
            nlsa_pkg::ST_NORM:
                if (step_reg == 6'(nlsa_pkg::NORM_STEPS - 1))
                    state_next = nlsa_pkg::ST_FOLD;
            nlsa_pkg::ST_FOLD:
                state_next = nlsa_pkg::ST_DIV;
            nlsa_pkg::ST_DIV:
                if (step_reg == 6'(nlsa_pkg::DIV_STEPS - 1))
                    state_next = nlsa_pkg::ST_MUL;
            nlsa_pkg::ST_MUL:
                if (mrsp.done)
                    state_next = nlsa_pkg::ST_POST;
            nlsa_pkg::ST_POST:
                state_next = (op_reg == nlsa_pkg::OP_TERM) ?
                             nlsa_pkg::ST_SCORE : nlsa_pkg::ST_MUL;
            nlsa_pkg::ST_SCORE:
                state_next = nlsa_pkg::ST_UPDATE;
            nlsa_pkg::ST_UPDATE:
                if (!item_reg.last || out_free)
                    state_next = nlsa_pkg::ST_IDLE;
            default:
                state_next = nlsa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        item_next      = item_reg;
        mreq_next      = mreq_reg;
        mreq_next.start = 1'b0;
        z_next         = z_reg;
        lz_next        = lz_reg;
        step_next      = step_reg;
        e_next         = e_reg;
        fneg_next      = fneg_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        poly_next      = poly_reg;
        lnterm_next    = lnterm_reg;
        lneg_next      = lneg_reg;
        term_next      = term_reg;
        score_next     = score_reg;
        min_next       = min_reg;
        min_idx_next   = min_idx_reg;
        have_next      = have_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_score_next = out_score_reg;
        out_idx_next   = out_idx_reg;
        q_pop          = 1'b0;

        amt      = nlsa_pkg::norm_amt(step_reg[2:0]);
        topmask  = ~(64'hFFFF_FFFF_FFFF_FFFF >> amt);
        mn       = z_reg >> 2;
        rem2     = rem_reg << 1;
        rnd      = mrsp.prod;
        prod_q60 = mrsp.prod[123:60];
        eterm    = '0;
        lg       = '0;
        ae       = e_reg[7] ? 8'(-e_reg) : 8'(e_reg);
        sum      = {item_reg.base[63], item_reg.base} + {term_reg[63], term_reg};
        take     = !have_reg || ($signed(score_reg) < min_reg);

        case (state_reg)
            nlsa_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    z_next    = q_item.x;
                    lz_next   = '0;
                    step_next = '0;
                end
            end
            nlsa_pkg::ST_NORM:
            begin
                // Binary leading-one search, one shift width per cycle.
                if ((z_reg & topmask) == 64'd0)
                begin
                    z_next  = z_reg << amt;
                    lz_next = lz_reg + 6'(amt);
                end
                step_next = step_reg + 6'd1;
            end
            nlsa_pkg::ST_FOLD:
            begin
                // Mantissa in Q.61; fold above sqrt2 into the next octave.
                e_next    = 8'sd40 - $signed({2'b00, lz_reg});
                fneg_next = 1'b0;
                rem_next  = mn - nlsa_pkg::ONE61;
                den_next  = mn + nlsa_pkg::ONE61;
                if (mn > nlsa_pkg::SQRT2_Q61)
                begin
                    e_next    = 8'sd41 - $signed({2'b00, lz_reg});
                    fneg_next = 1'b1;
                    rem_next  = nlsa_pkg::TWO61 - mn;
                    den_next  = mn + nlsa_pkg::TWO61;
                end
                t_next    = '0;
                step_next = '0;
            end
            nlsa_pkg::ST_DIV:
            begin
                if (rem2 >= den_reg)
                begin
                    rem_next = rem2 - den_reg;
                    t_next   = {t_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2;
                    t_next   = {t_reg[62:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(nlsa_pkg::DIV_STEPS - 1))
                begin
                    op_next   = nlsa_pkg::OP_SQ;
                    mreq_next = '{start: 1'b1, a: t_next, b: t_next};
                end
            end
            nlsa_pkg::ST_POST:
            begin
                case (op_reg)
                    nlsa_pkg::OP_SQ:
                    begin
                        s_next    = prod_q60;
                        poly_next = nlsa_pkg::COEF_13;
                        step_next = '0;
                        op_next   = nlsa_pkg::OP_HORN;
                        mreq_next = '{start: 1'b1, a: nlsa_pkg::COEF_13, b: prod_q60};
                    end
                    nlsa_pkg::OP_HORN:
                    begin
                        poly_next = prod_q60 + nlsa_pkg::horner_coef(step_reg[2:0]);
                        step_next = step_reg + 6'd1;
                        if (step_reg == 6'(nlsa_pkg::HORNER_STEPS - 1))
                        begin
                            op_next   = nlsa_pkg::OP_LN;
                            mreq_next = '{start: 1'b1, a: t_reg << 1, b: poly_next};
                        end
                        else
                        begin
                            mreq_next = '{start: 1'b1, a: poly_next, b: s_reg};
                        end
                    end
                    nlsa_pkg::OP_LN:
                    begin
                        op_next   = nlsa_pkg::OP_LNT;
                        mreq_next = '{start: 1'b1, a: prod_q60,
                                      b: nlsa_pkg::LOG10_E_Q64};
                    end
                    nlsa_pkg::OP_LNT:
                    begin
                        rnd         = mrsp.prod + (128'd1 << 67);
                        lnterm_next = {4'd0, rnd[127:68]};
                        op_next     = nlsa_pkg::OP_EXP;
                        mreq_next   = '{start: 1'b1, a: {56'd0, ae},
                                        b: nlsa_pkg::LOG10_2_Q64};
                    end
                    nlsa_pkg::OP_EXP:
                    begin
                        rnd       = mrsp.prod + (128'd1 << 7);
                        eterm     = rnd[71:8];
                        lg        = (e_reg[7] ? (64'd0 - eterm) : eterm) +
                                    (fneg_reg ? (64'd0 - lnterm_reg) : lnterm_reg);
                        lneg_next = lg[63];
                        op_next   = nlsa_pkg::OP_TERM;
                        mreq_next = '{start: 1'b1, a: {16'd0, item_reg.smag},
                                      b: lg[63] ? (64'd0 - lg) : lg};
                    end
                    nlsa_pkg::OP_TERM:
                    begin
                        rnd       = mrsp.prod + (128'd1 << 55);
                        term_next = (item_reg.sneg != lneg_reg) ?
                                    (64'd0 - rnd[119:56]) : rnd[119:56];
                    end
                    default:
                    begin
                        term_next = term_reg;
                    end
                endcase
            end
            nlsa_pkg::ST_SCORE:
            begin
                if (sum[64] != sum[63])
                    score_next = sum[64] ? 64'h8000_0000_0000_0000
                                         : 64'h7FFF_FFFF_FFFF_FFFF;
                else
                    score_next = sum[63:0];
            end
            nlsa_pkg::ST_UPDATE:
            begin
                if (!item_reg.last || out_free)
                begin
                    if (take)
                    begin
                        min_next     = $signed(score_reg);
                        min_idx_next = item_reg.idx[INDEX_BITS-1:0];
                        have_next    = 1'b1;
                    end
                    if (item_reg.last)
                    begin
                        out_valid_next = 1'b1;
                        out_score_next = take ? score_reg : min_reg;
                        out_idx_next   = take ? item_reg.idx[INDEX_BITS-1:0]
                                              : min_idx_reg;
                        have_next      = 1'b0;
                    end
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nlsa_pkg::ST_IDLE;
            op_reg        <= nlsa_pkg::OP_SQ;
            mreq_reg      <= '0;
            step_reg      <= '0;
            min_reg       <= '0;
            min_idx_reg   <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            mreq_reg      <= mreq_next;
            step_reg      <= step_next;
            min_reg       <= min_next;
            min_idx_reg   <= min_idx_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        z_reg         <= z_next;
        lz_reg        <= lz_next;
        e_reg         <= e_next;
        fneg_reg      <= fneg_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        t_reg         <= t_next;
        s_reg         <= s_next;
        poly_reg      <= poly_next;
        lnterm_reg    <= lnterm_next;
        lneg_reg      <= lneg_next;
        term_reg      <= term_next;
        score_reg     <= score_next;
        out_score_reg <= out_score_next;
        out_idx_reg   <= out_idx_next;
    end

    assign out_valid  = out_valid_reg;
    assign best_score = $signed(out_score_reg);
    assign best_at    = 32'(out_idx_reg);

endmodule

[hdl/nfa_log_score_argmin_top.sv]
`timescale 1ns / 1ps

// Streaming argmin of a log-residual score. Each input transaction on the
// in_valid / in_stall channel carries a candidate index, its residual and two
// table values. The block forms base_term + scale_term * log10(residual + 1 LSB)
// in signed Q.32 with saturation and keeps the earliest smallest score.
// A transaction with run_last set produces one result transaction on the
// out_valid / out_stall channel with the best score and its index; other
// transactions produce none, and a new run starts after each result.
// Accepted transactions go into a two-entry queue, so the sender can run ahead
// while the back end works. Each item passes through the back end in turn:
// a binary leading-one search, a bit-serial divider and eleven passes
// through a shared multiplier that builds every 64x64 product from four
// 32x32 partial products. The result is registered once the last item of a
// run has been scored and the output is free; the back end takes one item at a time.
// Reset clears the queue, the running minimum and the output valid flag. While
// the receiver holds out_stall, the result waits in the output register; a
// further run_last item then waits in the back end, and the queue fills until
// in_stall rises.

module nfa_log_score_argmin_top #(
    parameter int INDEX_BITS = nlsa_pkg::INDEX_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         cand_index,
    input  logic [62:0]         residual,
    input  logic signed [63:0]  base_term,
    input  logic signed [47:0]  scale_term,
    input  logic                run_last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [63:0]  best_score,
    output logic [31:0]         best_at
);

    logic            q_valid;
    logic            q_pop;
    nlsa_pkg::item_t q_item;

    // Front end: classifies items and queues them.
    nlsa_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cand_index (cand_index),
        .residual   (residual),
        .base_term  (base_term),
        .scale_term (scale_term),
        .run_last   (run_last),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Back end: log10, score, running minimum and the result register.
    nlsa_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_score (best_score),
        .best_at    (best_at)
    );

endmodule

[tb/nfa_log_score_argmin_top_test.sv]
`timescale 1ns / 1ps

module nfa_log_score_argmin_top_test;

    localparam logic signed [63:0] SCORE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SCORE_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [62:0]        RES_MAX   = 63'h7FFF_FFFF_FFFF_FFFE;
    // A scale of 1.0 in the Q.32 scale table.
    localparam logic signed [47:0] SCALE_ONE = 48'sh0001_0000_0000;

    // A row of the directed table. When known is set, the run closed by this
    // row has an outcome that is obvious by inspection, and the predictor is
    // cross-checked against the typed values.
    typedef struct {
        logic [31:0]        idx;
        logic [62:0]        res;
        logic signed [63:0] base;
        logic signed [47:0] scale;
        logic               last;
        bit                 known;
        logic signed [63:0] want_score;
        logic [31:0]        want_at;
    } row_t;

    typedef struct {
        logic signed [63:0] score;
        logic [31:0]        at;
    } best_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        cand_index;
    logic [62:0]        residual;
    logic signed [63:0] base_term;
    logic signed [47:0] scale_term;
    logic               run_last;
    logic               out_valid;
    logic               out_stall;
    logic signed [63:0] best_score;
    logic [31:0]        best_at;

    // Predictor state: the running argmin of the current run.
    logic signed [63:0] min_score;
    logic [31:0]        min_at;
    bit                 min_valid;

    best_t pending_best[$];
    int    errors;
    int    send_idle_pct;
    int    stall_pct;
    bit    hold;
    bit    start_hold;

    nfa_log_score_argmin_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cand_index (cand_index),
        .residual   (residual),
        .base_term  (base_term),
        .scale_term (scale_term),
        .run_last   (run_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_score (best_score),
        .best_at    (best_at)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // (a * b, optionally plus half an output LSB) shifted right by sh, kept to 64 bits.
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int sh, input bit rnd);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if (rnd)
        begin
            prod = prod + (128'd1 << (sh - 1));
        end
        return 64'(prod >> sh);
    endfunction

    // log10(residual + 1 LSB) in signed Q.56.
    function automatic logic signed [63:0] log10_q56(input logic [62:0] r);
        logic [63:0] x, mn, num, den, t, rem, s, poly, lnmag, lnterm, ae, eterm;
        int          p;
        int          e;
        bit          neg;
        x = {1'b0, r} + 64'd1;
        p = 63;
        while (p > 0 && !x[p])
        begin
            p--;
        end
        e = p - 23;
        mn = (p <= 61) ? (x << (61 - p)) : (x >> (p - 61));
        // Fold the mantissa into [sqrt2/2, sqrt2] so the series converges fast.
        neg = (mn > nlsa_pkg::SQRT2_Q61);
        if (neg)
        begin
            e++;
            num = nlsa_pkg::TWO61 - mn;
            den = mn + nlsa_pkg::TWO61;
        end
        else
        begin
            num = mn - nlsa_pkg::ONE61;
            den = mn + nlsa_pkg::ONE61;
        end
        t = 64'd0;
        rem = num;
        for (int i = 0; i < 60; i++)
        begin
            rem = rem << 1;
            t = t << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                t[0] = 1'b1;
            end
        end
        s = mul_shift(t, t, 60, 1'b0);
        poly = nlsa_pkg::COEF_13;
        poly = mul_shift(poly, s, 60, 1'b0) + nlsa_pkg::COEF_11;
        poly = mul_shift(poly, s, 60, 1'b0) + nlsa_pkg::COEF_9;
        poly = mul_shift(poly, s, 60, 1'b0) + nlsa_pkg::COEF_7;
        poly = mul_shift(poly, s, 60, 1'b0) + nlsa_pkg::COEF_5;
        poly = mul_shift(poly, s, 60, 1'b0) + nlsa_pkg::COEF_3;
        poly = mul_shift(poly, s, 60, 1'b0) + nlsa_pkg::ONE60;
        lnmag = mul_shift(t << 1, poly, 60, 1'b0);
        lnterm = mul_shift(lnmag, nlsa_pkg::LOG10_E_Q64, 68, 1'b1);
        ae = (e < 0) ? 64'(-e) : 64'(e);
        eterm = mul_shift(ae, nlsa_pkg::LOG10_2_Q64, 8, 1'b1);
        return $signed((e < 0) ? -eterm : eterm) + $signed(neg ? -lnterm : lnterm);
    endfunction

    // Score of one candidate, saturated to the signed 64-bit range.
    function automatic logic signed [63:0] score_of(input logic [62:0] r,
                                                    input logic signed [63:0] base,
                                                    input logic signed [47:0] scale);
        logic signed [63:0] sx, lg, term;
        logic [63:0]        smag, lmag;
        logic signed [64:0] sum;
        bit                 sneg, lneg;
        sx = scale;
        sneg = scale[47];
        smag = sneg ? -sx : sx;
        lg = log10_q56(r);
        lneg = lg[63];
        lmag = lneg ? -lg : lg;
        term = mul_shift(smag, lmag, 56, 1'b1);
        if (sneg != lneg)
        begin
            term = -term;
        end
        sum = {base[63], base} + {term[63], term};
        if (sum > 65'sd0 && sum[64:63] == 2'b01)
        begin
            return SCORE_MAX;
        end
        if (sum[64:63] == 2'b10)
        begin
            return SCORE_MIN;
        end
        return sum[63:0];
    endfunction

    // Offers one transaction, waits until it is taken, then updates the running
    // argmin. Returns 1 with the expected result when the transaction closes a run.
    task automatic offer(input row_t row, output bit closed, output best_t best);
        logic signed [63:0] sc;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cand_index <= row.idx;
        residual   <= row.res;
        base_term  <= row.base;
        scale_term <= row.scale;
        run_last   <= row.last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sc = score_of(row.res, row.base, row.scale);
        // Ties keep the earlier candidate, so only a strictly smaller score wins.
        if (!min_valid || sc < min_score)
        begin
            min_score = sc;
            min_at = row.idx;
            min_valid = 1'b1;
        end
        closed = row.last;
        best.score = min_score;
        best.at = min_at;
        if (row.last)
        begin
            pending_best.push_back(best);
            min_valid = 1'b0;
        end
    endtask

    // Residuals spread over all magnitudes, with the extremes now and then.
    function automatic logic [62:0] random_residual();
        logic [62:0] r;
        r = 63'({$urandom, $urandom}) >> $urandom_range(0, 62);
        case ($urandom_range(0, 15))
            0: r = 63'd0;
            1: r = RES_MAX;
            2: r = 63'd8388607;
            default: ;
        endcase
        if (r > RES_MAX)
        begin
            r = RES_MAX;
        end
        return r;
    endfunction

    task automatic random_runs(input int count);
        row_t  row;
        bit    closed;
        best_t best;
        int    sent;
        int    len;
        sent = 0;
        while (sent < count)
        begin
            // Runs are mostly short so results come often; a few are long.
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                row.idx = $urandom;
                row.res = random_residual();
                // Small bases let the log term decide the ordering; full-range
                // bases exercise saturation.
                row.base = ($urandom_range(0, 3) == 0) ? $signed({$urandom, $urandom})
                                                       : 64'($signed(32'($urandom)));
                row.scale = $signed({16'($urandom), $urandom});
                if ($urandom_range(0, 9) == 0)
                begin
                    row.scale = $urandom_range(0, 1) ? 48'sh7FFF_FFFF_FFFF
                                                     : 48'sh8000_0000_0000;
                end
                if ($urandom_range(0, 9) == 0 && i > 0)
                begin
                    // Repeat the previous score to exercise tie handling.
                    row.res = residual;
                    row.base = base_term;
                    row.scale = scale_term;
                end
                row.last = (i == len - 1);
                row.known = 1'b0;
                offer(row, closed, best);
                sent++;
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result checker: each result transaction must match the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_best.size() == 0)
            begin
                report("unexpected result, best_score", best_score, 64'd0);
            end
            else
            begin
                if (best_score !== pending_best[0].score)
                begin
                    report("best_score", best_score, pending_best[0].score);
                end
                if (best_at !== pending_best[0].at)
                begin
                    report("best_at", best_at, pending_best[0].at);
                end
                void'(pending_best.pop_front());
            end
        end
    end

    // Receiver back-pressure: random stalls per phase, or a long hold-off.
    always @(posedge clk)
    begin
        out_stall <= hold || ($urandom_range(0, 99) < stall_pct);
    end

    // The long hold-off keeps the result register full while the sender keeps
    // offering, so the input queue fills and in_stall rises.
    initial
    begin
        hold = 1'b0;
        wait (start_hold);
        @(posedge clk);
        hold <= 1'b1;
        repeat (3000) @(posedge clk);
        hold <= 1'b0;
    end

    initial
    begin
        #(40_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        row_t  rows[$];
        bit    closed;
        best_t best;
        int    settle;

        errors = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        start_hold = 1'b0;
        min_valid = 1'b0;
        min_score = '0;
        min_at = '0;
        in_valid = 1'b0;
        cand_index = '0;
        residual = '0;
        base_term = '0;
        scale_term = '0;
        run_last = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With a zero scale the score is just the base, so
        // those outcomes can be typed in directly.
        // Single-item run with the smallest residual.
        rows.push_back('{32'd7, 63'd0, 64'sd100, 48'sd0, 1'b1, 1'b1, 64'sd100, 32'd7});
        // Extreme index and residual, top and bottom of the score range.
        rows.push_back('{32'hFFFF_FFFF, RES_MAX, SCORE_MAX, 48'sd0, 1'b1, 1'b1,
                         SCORE_MAX, 32'hFFFF_FFFF});
        rows.push_back('{32'd0, RES_MAX, SCORE_MIN, 48'sd0, 1'b1, 1'b1, SCORE_MIN, 32'd0});
        // Score overflow saturates upward and downward.
        rows.push_back('{32'd1, RES_MAX, SCORE_MAX, 48'sh7FFF_FFFF_FFFF, 1'b1, 1'b1,
                         SCORE_MAX, 32'd1});
        rows.push_back('{32'd2, RES_MAX, SCORE_MIN, 48'sh8000_0000_0000, 1'b1, 1'b1,
                         SCORE_MIN, 32'd2});
        // Equal scores: the earliest item is kept.
        rows.push_back('{32'd10, 63'd5, -64'sd50, 48'sd0, 1'b0, 1'b0, 64'sd0, 32'd0});
        rows.push_back('{32'd11, 63'd9, -64'sd50, 48'sd0, 1'b0, 1'b0, 64'sd0, 32'd0});
        rows.push_back('{32'd12, 63'd0, 64'sd20, 48'sd0, 1'b1, 1'b1, -64'sd50, 32'd10});
        // The first item of a run is taken even when its score is large.
        rows.push_back('{32'd30, 63'd0, SCORE_MAX, 48'sd0, 1'b1, 1'b1, SCORE_MAX, 32'd30});
        // Log-dependent scores around the fold point and at large residuals.
        rows.push_back('{32'd20, 63'd123456, 64'sd0, SCALE_ONE, 1'b0, 1'b0, 64'sd0, 32'd0});
        rows.push_back('{32'd21, 63'd1 << 40, 64'sd0, -SCALE_ONE, 1'b0, 1'b0, 64'sd0, 32'd0});
        rows.push_back('{32'd22, 63'd8388607, 64'sd5, SCALE_ONE, 1'b0, 1'b0, 64'sd0, 32'd0});
        rows.push_back('{32'd23, 63'd11863283, 64'sd0, SCALE_ONE, 1'b0, 1'b0, 64'sd0, 32'd0});
        rows.push_back('{32'd24, 63'd11863284, 64'sd0, -SCALE_ONE, 1'b0, 1'b0, 64'sd0, 32'd0});
        rows.push_back('{32'd25, 63'd1 << 62, -64'sd1, 48'sh7FFF_FFFF_FFFF, 1'b0, 1'b0,
                         64'sd0, 32'd0});
        rows.push_back('{32'd26, 63'd1, 64'sd0, -48'sd1, 1'b1, 1'b0, 64'sd0, 32'd0});

        foreach (rows[i])
        begin
            offer(rows[i], closed, best);
            if (closed && rows[i].known)
            begin
                if (best.score !== rows[i].want_score)
                begin
                    report("directed best_score", best.score, rows[i].want_score);
                end
                if (best.at !== rows[i].want_at)
                begin
                    report("directed best_at", best.at, rows[i].want_at);
                end
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Random part in phases of different idling.
        random_runs(300);
        send_idle_pct = 81;
        random_runs(300);
        send_idle_pct = 0;
        stall_pct = 81;
        start_hold = 1'b1;
        random_runs(300);
        send_idle_pct = 30;
        stall_pct = 30;
        random_runs(300);
        send_idle_pct = 0;
        stall_pct = 0;
        random_runs(300);

        // Drain: wait for every expected result before the final check.
        settle = 0;
        while (pending_best.size() != 0 && settle < 200000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (600) @(posedge clk);

        if (errors == 0 && pending_best.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
